// File: sv/sfr_pkg.sv
// ============================================================================
// Stuffed frame receiver package
// Shared types, codes and constants for the byte-stuffed frame receiver.
// ============================================================================
`default_nettype none

package sfr_pkg;

    // Line codes of the byte-stuffing scheme.
    localparam logic [7:0] FLAG_BYTE    = 8'h7E;
    localparam logic [7:0] ESC_BYTE     = 8'h7D;
    localparam logic [7:0] ESC_FOR_FLAG = 8'h5E;
    localparam logic [7:0] ESC_FOR_ESC  = 8'h5D;

    // CRC-16/CCITT, MSB first.
    localparam logic [15:0] CRC_PRESET = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'h1021;

    // Register reset values.
    localparam logic [15:0] TIMEOUT_RESET = 16'd100;
    localparam logic [6:0]  MIN_LEN_RESET = 7'd12;

    // Default frame store depth and command queue depth.
    localparam int DEFAULT_BUFFER_DEPTH = 64;
    localparam int QUEUE_DEPTH          = 4;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN = 2'd1;

    typedef struct packed {
        logic [15:0] timeout_ms;
        logic [6:0]  min_frame_len;
    } t_cfg;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
        logic [9:0] elapsed_ms;
    } t_in_item;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_out_item;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_BODY = 2'd1,
        PH_ESC  = 2'd2
    } t_phase;

    typedef enum logic {
        CMD_STORE = 1'b0,
        CMD_EMIT  = 1'b1
    } t_cmd_op;

    typedef enum logic {
        BK_IDLE  = 1'b0,
        BK_DRAIN = 1'b1
    } t_back_state;

endpackage

`default_nettype wire

// File: sv/stuffed_frame_receiver_crc_check_top.sv
// ============================================================================
// Stuffed frame receiver with CRC check
// Top level: configuration registers, front end, command queue, back end.
// ============================================================================
// Usage:
// The input channel carries one transaction per line byte or time tick
// (i_in_valid / o_in_stall). Ticks advance a saturating idle timer; bytes are
// unstuffed, checked against CRC-16/CCITT and collected into a frame.
// The output channel (o_out_valid / i_out_stall) delivers each good frame
// byte by byte, the final byte marked by last_byte. Bad or short frames
// produce no output transaction.
// Throughput: one input transaction per cycle while the command queue has
// room. A closing flag costs a frame drain of one byte per cycle, set by the
// single read port of the frame store; meanwhile the queue (four entries)
// fills and the input is stalled until the drain ends. The first frame
// byte passes the command queue, the drain state and the output register.
// A stalled output holds its transaction and the drain pauses with it.
// Reset (synchronous, active low) returns to flag hunt with an empty frame,
// a zero idle timer and the register reset values. The configuration port
// is always ready; indexes beyond the two registers are ignored.
// ============================================================================
`default_nettype none

module stuffed_frame_receiver_crc_check_top #(
    parameter int BUFFER_DEPTH = sfr_pkg::DEFAULT_BUFFER_DEPTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    input  wire sfr_pkg::t_in_item              i_in_data,
    output logic                                o_in_stall,
    output logic                                o_out_valid,
    output sfr_pkg::t_out_item                  o_out_data,
    input  wire logic                           i_out_stall,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [sfr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [sfr_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sfr_pkg::*;

    localparam int CW    = $clog2(BUFFER_DEPTH + 1);
    localparam int CMD_W = 1 + 8 + CW;

    t_cfg             r_cfg;
    logic             w_push;
    logic             w_pop;
    logic             w_q_full;
    logic             w_q_empty;
    logic [CMD_W-1:0] w_cmd_in;
    logic [CMD_W-1:0] w_cmd_out;

    // The register file takes a write in every cycle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout_ms    <= TIMEOUT_RESET;
            r_cfg.min_frame_len <= MIN_LEN_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TIMEOUT: begin
                    r_cfg.timeout_ms <= i_cfg_data;
                end
                CFG_MIN_LEN: begin
                    r_cfg.min_frame_len <= i_cfg_data[6:0];
                end
                default: begin
                end
            endcase
        end
    end

    // The front end classifies each transaction and turns it into at most one
    // command: store a byte at an address, or emit the stored frame.
    sfr_front #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_in_valid),
        .i_item   (i_in_data),
        .o_stall  (o_in_stall),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_cmd    (w_cmd_in)
    );

    // Commands queue here so a frame drain does not block the front end
    // until the queue is full; later stores wait behind the emit.
    sfr_fifo #(
        .WIDTH(CMD_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_push),
        .i_wr_data (w_cmd_in),
        .i_pop     (w_pop),
        .o_rd_data (w_cmd_out),
        .o_full    (w_q_full),
        .o_empty   (w_q_empty)
    );

    // The back end owns the frame store and the output register.
    sfr_back #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (w_q_empty),
        .i_cmd       (w_cmd_out),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    // A command is never pushed into a full queue.
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_q_full))
        else $error("command pushed into a full queue");

    // A store command addresses an entry inside the frame store.
    a_store_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && (w_cmd_in[CMD_W-1] == CMD_STORE)) |->
            (w_cmd_in[CW-1:0] < CW'(BUFFER_DEPTH)))
        else $error("store address beyond the frame store");

    // An emit command carries a nonempty length that fits the store.
    a_emit_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && (w_cmd_in[CMD_W-1] == CMD_EMIT)) |->
            ((w_cmd_in[CW-1:0] != '0) && (w_cmd_in[CW-1:0] <= CW'(BUFFER_DEPTH))))
        else $error("emit command with a bad frame length");

    // No output transaction is offered in the cycle after reset.
    a_quiet_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");

endmodule

`default_nettype wire

// File: sv/sfr_fifo.sv
// ============================================================================
// Stuffed frame receiver command queue
// Small first-in first-out queue between the classifier and the frame store.
// ============================================================================
`default_nettype none

module sfr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = sfr_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_rd_data,
    output logic                  o_full,
    output logic                  o_empty
);
    import sfr_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [NW-1:0]    r_fill, n_fill;
    logic             w_do_push, w_do_pop;

    assign o_full    = (r_fill == NW'(DEPTH));
    assign o_empty   = (r_fill == '0);
    assign o_rd_data = r_slot[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (w_do_push && !w_do_pop) begin
            n_fill = r_fill + NW'(1);
        end else if (w_do_pop && !w_do_push) begin
            n_fill = r_fill - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_slot[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

`default_nettype wire

// File: sv/sfr_front.sv
// ============================================================================
// Stuffed frame receiver front end
// Accepts line bytes and ticks, tracks framing, CRC and idle time, and
// issues store and emit commands to the queue.
// ============================================================================
`default_nettype none

module sfr_front #(
    parameter  int BUFFER_DEPTH = sfr_pkg::DEFAULT_BUFFER_DEPTH,
    localparam int AW           = $clog2(BUFFER_DEPTH),
    localparam int CW           = $clog2(BUFFER_DEPTH + 1),
    localparam int CMD_W        = 1 + 8 + CW
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire sfr_pkg::t_cfg     i_cfg,
    input  wire logic              i_valid,
    input  wire sfr_pkg::t_in_item i_item,
    output logic                   o_stall,
    input  wire logic              i_q_full,
    output logic                   o_push,
    output logic       [CMD_W-1:0] o_cmd
);
    import sfr_pkg::*;

    localparam int CMP_W = (CW > 7) ? CW : 7;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    t_phase      r_phase, n_phase;
    logic [CW-1:0] r_count, n_count;
    logic [15:0] r_crc, n_crc;
    logic [15:0] r_timer, n_timer;

    logic          w_accept;
    t_phase        w_phase_v;
    logic [CW-1:0] w_count_v;
    logic [15:0]   w_crc_v;
    logic          w_do_store;
    logic [7:0]    w_store_byte;
    logic [16:0]   w_timer_sum;
    t_cmd_op       w_op;
    logic [7:0]    w_cmd_data;
    logic [CW-1:0] w_cmd_count;

    // The queue backs up while a frame drains; items wait at the port then.
    assign o_stall  = i_q_full;
    assign w_accept = i_valid && !i_q_full;
    assign o_cmd    = {w_op, w_cmd_data, w_cmd_count};

    always_comb begin
        n_phase      = r_phase;
        n_count      = r_count;
        n_crc        = r_crc;
        n_timer      = r_timer;
        w_phase_v    = r_phase;
        w_count_v    = r_count;
        w_crc_v      = r_crc;
        w_do_store   = 1'b0;
        w_store_byte = i_item.rx_byte;
        w_timer_sum  = {1'b0, r_timer} + {7'b0, i_item.elapsed_ms};
        o_push       = 1'b0;
        w_op         = CMD_STORE;
        w_cmd_data   = i_item.rx_byte;
        w_cmd_count  = r_count;

        if (w_accept) begin
            if (i_item.action) begin
                n_timer = w_timer_sum[16] ? 16'hFFFF : w_timer_sum[15:0];
            end else begin
                // A silence longer than the timeout discards the partial frame.
                if (r_timer > i_cfg.timeout_ms) begin
                    w_phase_v = PH_HUNT;
                    w_count_v = '0;
                    w_crc_v   = CRC_PRESET;
                end
                n_timer = '0;
                n_phase = w_phase_v;
                n_count = w_count_v;
                n_crc   = w_crc_v;

                unique case (w_phase_v)
                    PH_HUNT: begin
                        if (i_item.rx_byte == FLAG_BYTE) begin
                            n_phase = PH_BODY;
                        end
                    end
                    PH_BODY: begin
                        if (i_item.rx_byte == FLAG_BYTE) begin
                            if ((w_count_v != '0) && (w_crc_v == '0) &&
                                (CMP_W'(w_count_v) >= CMP_W'(i_cfg.min_frame_len))) begin
                                o_push      = 1'b1;
                                w_op        = CMD_EMIT;
                                w_cmd_count = w_count_v;
                            end
                            n_phase = PH_BODY;
                            n_count = '0;
                            n_crc   = CRC_PRESET;
                        end else if (i_item.rx_byte == ESC_BYTE) begin
                            n_phase = PH_ESC;
                        end else begin
                            w_do_store = 1'b1;
                        end
                    end
                    PH_ESC: begin
                        if (i_item.rx_byte == ESC_FOR_FLAG) begin
                            w_do_store   = 1'b1;
                            w_store_byte = FLAG_BYTE;
                        end else if (i_item.rx_byte == ESC_FOR_ESC) begin
                            w_do_store   = 1'b1;
                            w_store_byte = ESC_BYTE;
                        end else begin
                            n_phase = PH_HUNT;
                            n_count = '0;
                            n_crc   = CRC_PRESET;
                        end
                    end
                    default: begin
                        n_phase = PH_HUNT;
                        n_count = '0;
                        n_crc   = CRC_PRESET;
                    end
                endcase

                if (w_do_store) begin
                    if (w_count_v == CW'(BUFFER_DEPTH)) begin
                        // Overflow: the byte is dropped and the receiver cleared.
                        n_phase = PH_HUNT;
                        n_count = '0;
                        n_crc   = CRC_PRESET;
                    end else begin
                        o_push      = 1'b1;
                        w_op        = CMD_STORE;
                        w_cmd_data  = w_store_byte;
                        w_cmd_count = CW'(w_count_v[AW-1:0]);
                        n_phase     = PH_BODY;
                        n_count     = w_count_v + CW'(1);
                        n_crc       = crc_feed(w_crc_v, w_store_byte);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_count <= '0;
            r_crc   <= CRC_PRESET;
            r_timer <= '0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_crc   <= n_crc;
            r_timer <= n_timer;
        end
    end

endmodule

`default_nettype wire

// File: sv/sfr_back.sv
// ============================================================================
// Stuffed frame receiver back end
// Executes queued commands: writes the frame store and drains whole frames
// to the output register.
// ============================================================================
`default_nettype none

module sfr_back #(
    parameter  int BUFFER_DEPTH = sfr_pkg::DEFAULT_BUFFER_DEPTH,
    localparam int AW           = $clog2(BUFFER_DEPTH),
    localparam int CW           = $clog2(BUFFER_DEPTH + 1),
    localparam int CMD_W        = 1 + 8 + CW
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_empty,
    input  wire logic   [CMD_W-1:0] i_cmd,
    output logic                    o_pop,
    output logic                    o_out_valid,
    output sfr_pkg::t_out_item      o_out_data,
    input  wire logic               i_out_stall
);
    import sfr_pkg::*;

    t_back_state   r_state, n_state;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_len, n_len;
    logic          r_out_valid;
    logic          r_out_last;
    logic [7:0]    r_rd_data;
    logic [7:0]    r_mem [BUFFER_DEPTH];

    t_cmd_op       w_op;
    logic [7:0]    w_cmd_data;
    logic [CW-1:0] w_cmd_count;
    logic          w_we;
    logic          w_rd_en;
    logic          w_last;
    logic [CW-1:0] w_idx_inc;

    assign w_op        = t_cmd_op'(i_cmd[CMD_W-1]);
    assign w_cmd_data  = i_cmd[CMD_W-2 -: 8];
    assign w_cmd_count = i_cmd[CW-1:0];
    assign w_idx_inc   = r_idx + CW'(1);
    assign w_last      = (w_idx_inc == r_len);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_len   = r_len;
        o_pop   = 1'b0;
        w_we    = 1'b0;
        w_rd_en = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    o_pop = 1'b1;
                    if (w_op == CMD_EMIT) begin
                        n_state = BK_DRAIN;
                        n_idx   = '0;
                        n_len   = w_cmd_count;
                    end else begin
                        w_we = 1'b1;
                    end
                end
            end
            BK_DRAIN: begin
                // One read per cycle whenever the output register frees up.
                if (!r_out_valid || !i_out_stall) begin
                    w_rd_en = 1'b1;
                    n_idx   = w_idx_inc;
                    if (w_last) begin
                        n_state = BK_IDLE;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_idx       <= '0;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_len   <= n_len;
            if (w_rd_en) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_cmd_count[AW-1:0]] <= w_cmd_data;
        end
        if (w_rd_en) begin
            r_rd_data  <= r_mem[r_idx[AW-1:0]];
            r_out_last <= w_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = '{frame_byte: r_rd_data, last_byte: r_out_last};

endmodule

`default_nettype wire

// File: tb/deframe_checker.sv
// ============================================================================
// Deframer checker
// Watches the input, output and configuration channels of the stuffed frame
// receiver, predicts every delivered frame byte and compares it in order.
// ============================================================================
`default_nettype none

module deframe_checker #(
    parameter int DEPTH = sfr_pkg::DEFAULT_BUFFER_DEPTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    input  wire logic                           i_in_stall,
    input  wire sfr_pkg::t_in_item              i_in_data,
    input  wire logic                           i_out_valid,
    input  wire logic                           i_out_stall,
    input  wire sfr_pkg::t_out_item             i_out_data,
    input  wire logic                           i_cfg_valid,
    input  wire logic                           i_cfg_ready,
    input  wire logic [sfr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [sfr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                                  o_pending,
    output int                                  o_fail_count
);
    import sfr_pkg::*;

    localparam logic ACT_TICK     = 1'b1;
    localparam int   REPORT_LIMIT = 10;

    logic [15:0] timeout_ms;
    logic [6:0]  min_len;
    t_phase      phase;
    logic [7:0]  frame_buf [DEPTH];
    int          frame_len;
    logic [15:0] crc;
    int unsigned silence_ms;
    t_out_item   due_bytes [$];
    int          mismatches;
    int          seen_bytes;

    function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
        end
        return r;
    endfunction

    function automatic void clear_frame();
        phase     = PH_HUNT;
        frame_len = 0;
        crc       = CRC_PRESET;
    endfunction

    // A byte that finds the store full clears the receiver and is lost.
    function automatic bit keep_byte(input logic [7:0] b);
        if (frame_len >= DEPTH) begin
            clear_frame();
            return 1'b0;
        end
        frame_buf[frame_len] = b;
        frame_len++;
        crc = crc_next(crc, b);
        return 1'b1;
    endfunction

    task automatic deframe_item(input t_in_item item);
        if (item.action == ACT_TICK) begin
            silence_ms += item.elapsed_ms;
            if (silence_ms > 32'hFFFF) silence_ms = 32'hFFFF;
        end else begin
            if (silence_ms > timeout_ms) clear_frame();
            silence_ms = 0;
            case (phase)
                PH_HUNT: begin
                    if (item.rx_byte == FLAG_BYTE) phase = PH_BODY;
                end
                PH_BODY: begin
                    if (item.rx_byte == FLAG_BYTE) begin
                        if (frame_len > 0 && frame_len >= min_len && crc == 16'h0000) begin
                            for (int k = 0; k < frame_len; k++) begin
                                due_bytes.push_back('{frame_byte: frame_buf[k],
                                                      last_byte: (k == frame_len - 1)});
                            end
                        end
                        clear_frame();
                        phase = PH_BODY;
                    end else if (item.rx_byte == ESC_BYTE) begin
                        phase = PH_ESC;
                    end else begin
                        void'(keep_byte(item.rx_byte));
                    end
                end
                PH_ESC: begin
                    if (item.rx_byte == ESC_FOR_FLAG) begin
                        if (keep_byte(FLAG_BYTE)) phase = PH_BODY;
                    end else if (item.rx_byte == ESC_FOR_ESC) begin
                        if (keep_byte(ESC_BYTE)) phase = PH_BODY;
                    end else begin
                        clear_frame();
                    end
                end
                default: clear_frame();
            endcase
        end
    endtask

    task automatic note_mismatch(input bit have_want, input t_out_item want,
                                 input t_out_item got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            if (have_want)
                $display("frame byte %0d: expected %02h last %0d, got %02h last %0d",
                         seen_bytes, want.frame_byte, want.last_byte,
                         got.frame_byte, got.last_byte);
            else
                $display("frame byte %0d: none expected, got %02h last %0d",
                         seen_bytes, got.frame_byte, got.last_byte);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            timeout_ms = TIMEOUT_RESET;
            min_len    = MIN_LEN_RESET;
            silence_ms = 0;
            clear_frame();
            due_bytes.delete();
            mismatches = 0;
            seen_bytes = 0;
        end else begin
            // Outputs first: a result at this edge belongs to an earlier input.
            if (i_out_valid && !i_out_stall) begin
                if (due_bytes.size() == 0) begin
                    note_mismatch(1'b0, '0, i_out_data);
                end else begin
                    want = due_bytes.pop_front();
                    if (want.frame_byte != i_out_data.frame_byte ||
                        want.last_byte != i_out_data.last_byte)
                        note_mismatch(1'b1, want, i_out_data);
                end
                seen_bytes++;
            end
            // An input at this edge still sees the old register values.
            if (i_in_valid && !i_in_stall) deframe_item(i_in_data);
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_TIMEOUT)
                    timeout_ms = i_cfg_data[15:0];
                else if (i_cfg_index == CFG_MIN_LEN)
                    min_len = i_cfg_data[6:0];
            end
        end
        o_pending    = due_bytes.size();
        o_fail_count = mismatches + due_bytes.size();
    end

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// ============================================================================
// Stuffed frame receiver testbench
// Drives line bytes and time ticks into the receiver, with random gaps and
// output stalls, through several register settings; a separate checker
// predicts the delivered frames and counts every mismatch.
// ============================================================================
`default_nettype none

module tb_top;
    import sfr_pkg::*;

    localparam int   DEPTH           = DEFAULT_BUFFER_DEPTH;
    localparam logic ACT_BYTE        = 1'b0;
    localparam logic ACT_TICK        = 1'b1;
    // Index 3 addresses no register; a write to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    // Cycles allowed for transactions still in the command queue to retire
    // after the last expected frame byte has come out.
    localparam int   DRAIN_CYCLES    = 20;
    localparam int   HOLD_CYCLES     = 200;
    localparam int   PHASE_ITEMS     = 25;
    localparam int   WATCHDOG_LIMIT  = 2000;

    typedef logic [7:0] byte_q [$];

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    t_in_item              i_in_data;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_item             o_out_data;
    logic                  i_out_stall;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int          pending;
    int          fail_count;
    int          sent_items = 0;
    int          idle_run   = 0;
    bit          quiet      = 1'b0;
    bit          hold_req   = 1'b0;
    logic [15:0] cur_timeout = TIMEOUT_RESET;
    logic [6:0]  cur_min     = MIN_LEN_RESET;

    stuffed_frame_receiver_crc_check_top #(
        .BUFFER_DEPTH(DEPTH)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data),
        .i_out_stall(i_out_stall),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    deframe_checker #(
        .DEPTH(DEPTH)
    ) CHK (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_pending   (pending),
        .o_fail_count(fail_count)
    );

    // Clock with a period of 8 time units.
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // The watchdog counts edges at which no transaction moves on any channel.
    // The longest legal silence is the receiver hold-off, far below the limit.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_run <= 0;
        end else if (idle_run >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_run <= idle_run + 1;
        end
    end

    // Receiver side. It stalls in about a quarter of the cycles, never while
    // the quiet flag is set, and on request holds off for a long stretch so
    // that the block fills its queue and stalls the sender.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= !quiet && ($urandom_range(99) < 26);
            end
        end
    end

    function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
        end
        return r;
    endfunction

    // Random byte with the line codes made much more likely than chance.
    function automatic logic [7:0] random_byte();
        if ($urandom_range(7) != 0) return 8'($urandom);
        case ($urandom_range(3))
            0:       return FLAG_BYTE;
            1:       return ESC_BYTE;
            2:       return ESC_FOR_FLAG;
            default: return ESC_FOR_ESC;
        endcase
    endfunction

    // Tick length: mostly within the current timeout, now and then anything,
    // so that some frames are cut off by silence.
    function automatic logic [9:0] pick_elapsed();
        int cap;
        cap = (cur_timeout > 16'd1023) ? 1023 : int'(cur_timeout);
        if ($urandom_range(19) == 0) return 10'($urandom_range(1023));
        return 10'($urandom_range(cap));
    endfunction

    // Payload length (CRC not counted) of a frame sized from the current minimum.
    function automatic int pick_payload_len();
        int total;
        total = (cur_min > 7'd2) ? int'(cur_min) : 2;
        if ($urandom_range(5) == 0)
            total = $urandom_range(DEPTH, 2);
        else
            total = total + $urandom_range(6);
        if (total > DEPTH) total = DEPTH;
        return total - 2;
    endfunction

    // One input transaction. Inputs change at the falling edge; acceptance
    // is seen at the rising edge, and the task returns at the next falling
    // edge so that a following call may keep valid high without a glitch.
    task automatic send_item(input t_in_item item);
        while (!quiet && $urandom_range(99) < 26) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        sent_items++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item('{action: ACT_BYTE, rx_byte: b, elapsed_ms: 10'($urandom)});
    endtask

    task automatic send_tick(input logic [9:0] ms);
        send_item('{action: ACT_TICK, rx_byte: 8'($urandom), elapsed_ms: ms});
    endtask

    // Sends a payload with its CRC appended, stuffed, and a closing flag.
    // A corrupted frame has one bit flipped after the CRC was computed.
    task automatic send_frame(input byte_q body, input bit open_flag,
                              input bit with_ticks, input bit corrupt);
        logic [15:0] c;
        c = CRC_PRESET;
        foreach (body[k]) c = crc_next(c, body[k]);
        body.push_back(c[15:8]);
        body.push_back(c[7:0]);
        if (corrupt) body[$urandom_range(body.size() - 1)] ^= 8'(1 << $urandom_range(7));
        if (open_flag) send_byte(FLAG_BYTE);
        foreach (body[k]) begin
            if (with_ticks && $urandom_range(9) == 0) send_tick(pick_elapsed());
            if (body[k] == FLAG_BYTE) begin
                send_byte(ESC_BYTE);
                send_byte(ESC_FOR_FLAG);
            end else if (body[k] == ESC_BYTE) begin
                send_byte(ESC_BYTE);
                send_byte(ESC_FOR_ESC);
            end else begin
                send_byte(body[k]);
            end
        end
        send_byte(FLAG_BYTE);
    endtask

    task automatic send_random_frame(input int len, input bit corrupt);
        byte_q body;
        body = {};
        repeat (len) body.push_back(random_byte());
        send_frame(body, $urandom_range(9) < 7, 1'b1, corrupt);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
        if (idx == CFG_TIMEOUT) cur_timeout = data;
        else if (idx == CFG_MIN_LEN) cur_min = data[6:0];
    endtask

    // Stop sending, wait until every expected frame byte has come out, then
    // give the queue time to retire transactions that make no output.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic configure(input logic [15:0] timeout_val, input logic [6:0] min_val);
        settle();
        write_reg(CFG_TIMEOUT, timeout_val);
        write_reg(CFG_MIN_LEN, 16'(min_val));
    endtask

    // Random traffic: mostly well-formed frames with random content, plus
    // corrupted frames, broken escapes, frames at and past the store depth,
    // and line noise.
    task automatic run_traffic(input int goal);
        int pick;
        logic [7:0] b;
        while (sent_items < goal) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                send_random_frame(pick_payload_len(), 1'b0);
            end else if (pick < 70) begin
                send_random_frame(pick_payload_len(), 1'b1);
            end else if (pick < 80) begin
                send_byte(FLAG_BYTE);
                repeat ($urandom_range(4)) send_byte(random_byte());
                send_byte(ESC_BYTE);
                if ($urandom_range(1) == 0) begin
                    send_byte(FLAG_BYTE);
                end else begin
                    do b = 8'($urandom); while (b == ESC_FOR_FLAG || b == ESC_FOR_ESC);
                    send_byte(b);
                end
            end else if (pick < 86) begin
                // Exactly full, or one to two bytes past the store depth.
                send_random_frame(DEPTH - 2 + $urandom_range(2), 1'b0);
            end else begin
                repeat ($urandom_range(6, 1)) begin
                    if ($urandom_range(2) == 0) send_tick(10'($urandom_range(1023)));
                    else send_byte(random_byte());
                end
            end
        end
    endtask

    initial begin
        byte_q body;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part under the reset timeout with a two-byte minimum.
        write_reg(CFG_MIN_LEN, 16'd2);
        send_tick(10'd0);
        send_tick(10'd1023);
        send_byte(FLAG_BYTE);
        // The opening flag here closes an empty frame, which is never sent.
        // The payload needs both escapes.
        body = '{FLAG_BYTE, ESC_BYTE};
        send_frame(body, 1'b1, 1'b0, 1'b0);
        // Escape followed by an illegal code drops back to hunt.
        send_byte(ESC_BYTE);
        send_byte(8'h41);
        // A flag right after an escape also counts as a broken escape.
        send_byte(FLAG_BYTE);
        send_byte(ESC_BYTE);
        send_byte(FLAG_BYTE);
        // Long enough but with a bad CRC: dropped without output.
        send_byte(FLAG_BYTE);
        send_byte(8'h01);
        send_byte(8'h02);
        send_byte(FLAG_BYTE);
        // Silence equal to the timeout keeps the frame alive.
        send_tick(10'd100);
        body = '{8'h00, 8'hFF};
        send_frame(body, 1'b0, 1'b0, 1'b0);
        // One millisecond more clears the receiver before the byte.
        send_tick(10'd101);
        send_byte(8'h5A);

        // Reset values, with one long output hold-off while frames keep coming.
        configure(TIMEOUT_RESET, MIN_LEN_RESET);
        hold_req = 1'b1;
        send_random_frame(40, 1'b0);
        run_traffic(sent_items + PHASE_ITEMS);

        // Zero timeout and zero minimum, no idling on either side.
        configure(16'd0, 7'd0);
        quiet = 1'b1;
        run_traffic(sent_items + PHASE_ITEMS);
        quiet = 1'b0;

        // Largest timeout, minimum equal to the store depth. The idle timer saturates and, being
        // equal to the timeout, does not clear a full-size frame.
        configure(16'hFFFF, 7'd64);
        send_byte(FLAG_BYTE);
        repeat (66) send_tick(10'd1023);
        body = {};
        repeat (DEPTH - 2) body.push_back(random_byte());
        send_frame(body, 1'b0, 1'b0, 1'b0);
        run_traffic(sent_items + PHASE_ITEMS);

        configure(16'($urandom_range(2000)), 7'($urandom_range(20)));
        run_traffic(sent_items + PHASE_ITEMS);

        configure(16'($urandom), 7'($urandom_range(64)));
        write_reg(CFG_SPARE, 16'hFFFF);
        run_traffic(sent_items + PHASE_ITEMS);

        settle();
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
